// ----- src/tctrp_pkg.sv -----
// Shared constants and types for the type count table with random pick.
`timescale 1ns / 1ps

package tctrp_pkg;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned RND_W    = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned TCNT_W   = 16;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned DOUT_W   = 5;
  localparam int unsigned PICK_W   = 4;
  localparam int unsigned ACTIVE_W = 5;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 20'hFFFFF;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REM = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLR = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_PICK = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_LIST = 7'b0100000,
    S_DONE = 7'b1000000
  } seq_state_t;

endpackage

// ----- src/tctrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tctrp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tctrp_mod.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module tctrp_mod import tctrp_pkg::*; #(
  parameter int unsigned DIV_BITS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RND_W-1:0]    dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] rem
);

  localparam int unsigned STEP_W = $clog2(RND_W + 1);

  logic [RND_W-1:0]    quo;
  logic [DIV_BITS-1:0] dvs;
  logic [STEP_W-1:0]   steps;
  logic [DIV_BITS:0]   trial;
  logic                fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, quo[RND_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= STEP_W'(RND_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
      done  <= (steps == STEP_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Datapath: load on start, then one restoring step a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (steps != '0) begin
      quo <= {quo[RND_W-2:0], 1'b0};
      if (fits) begin
        rem <= DIV_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_BITS-1:0];
      end
    end
  end

endmodule

// ----- src/type_count_table_random_pick_top.sv -----
// Top level: count table, present list, sequencer and random pick.
// Sequence: table read, remainder start, remainder steps, done, list read, result load;
//   the remainder and list read are skipped when the list ends empty.
//   A remove that empties a type first rescans the table over the effective types.
// One request at a time: a new one is accepted only when idle; a held result stalls the next one.
// Reset (rst, synchronous): counts, total and present list empty, active_types = 16.
`timescale 1ns / 1ps

module type_count_table_random_pick_top import tctrp_pkg::*; #(
  parameter int unsigned MAX_TYPES  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: active_types
  input  logic                  cfg_we,
  input  logic [ACTIVE_W-1:0]   cfg_wdata,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] func, [9:2] piece_type, [25:10] random_value, [31:26] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [17:2] type_count, [37:18] total_left, [42:38] distinct_left,
  // [46:43] picked_type, [47] pick_valid
  output logic [M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IW  = $clog2(MAX_TYPES);
  localparam int unsigned DW  = $clog2(MAX_TYPES + 1);
  localparam int unsigned CEW = (COUNT_BITS > TCNT_W) ? COUNT_BITS : TCNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  seq_state_t state, state_next;

  logic [ACTIVE_W-1:0]   active_types;
  logic [DW-1:0]         eff_types;

  // request fields
  logic [FUNC_W-1:0]     func;
  logic [TYPE_W-1:0]     piece_type;
  logic [RND_W-1:0]      random_value;
  logic                  in_range;

  // table state
  logic [MAX_TYPES-1:0]  cnt_vld;
  logic [TOTAL_W-1:0]    total_count;
  logic [DW-1:0]         distinct_count;

  // scan walker
  logic [DW-1:0]         scan_t;
  logic                  scan_pend;
  logic [IW-1:0]         scan_idx;

  // result fields
  logic [STAT_W-1:0]     status;
  logic [TCNT_W-1:0]     type_count;
  logic [PICK_W-1:0]     picked_type;
  logic                  pick_valid;

  // RAM ports
  logic                  cnt_we;
  logic [IW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [IW-1:0]         cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  lst_we;
  logic [IW-1:0]         lst_waddr;
  logic [PICK_W-1:0]     lst_wdata;
  logic [IW-1:0]         lst_raddr;
  logic [PICK_W-1:0]     lst_rdata;

  // remainder unit
  logic                  div_start;
  logic                  div_done;
  logic [DW-1:0]         div_rem;

  // operation decode
  logic [IW-1:0]         tidx;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [CEW-1:0]        new_cnt_ext;
  logic                  add_ok;
  logic                  rem_ok;
  logic [STAT_W-1:0]     op_status;
  logic [COUNT_BITS-1:0] scan_cnt;
  logic                  scan_hit;
  logic                  list_room;
  logic                  out_free;

  // Clamp the active type count to the table depth
  always_comb begin
    if (32'(active_types) > 32'(MAX_TYPES)) begin
      eff_types = DW'(MAX_TYPES);
    end else begin
      eff_types = DW'(active_types);
    end
  end

  assign tidx      = piece_type[IW-1:0];
  assign cur_cnt   = cnt_vld[tidx] ? cnt_rdata : '0;
  assign list_room = 32'(distinct_count) < 32'(MAX_TYPES);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Decode the operation on the fetched count
  always_comb begin
    add_ok    = 1'b0;
    rem_ok    = 1'b0;
    op_status = ST_OK;
    case (func)
      FN_ADD: begin
        if (!in_range) begin
          op_status = ST_RANGE;
        end else if (cur_cnt == COUNT_MAX || total_count == TOTAL_MAX) begin
          op_status = ST_SAT;
        end else begin
          add_ok = 1'b1;
        end
      end
      FN_REM: begin
        if (!in_range) begin
          op_status = ST_RANGE;
        end else if (cur_cnt == '0) begin
          op_status = ST_EMPTY;
        end else begin
          rem_ok = 1'b1;
        end
      end
      default: begin
        op_status = ST_OK;
      end
    endcase
    if (add_ok) begin
      new_cnt = cur_cnt + COUNT_BITS'(1);
    end else if (rem_ok) begin
      new_cnt = cur_cnt - COUNT_BITS'(1);
    end else begin
      new_cnt = cur_cnt;
    end
    new_cnt_ext = CEW'(new_cnt);
  end

  // Scan stage: count of the entry read last cycle
  assign scan_cnt = cnt_vld[scan_idx] ? cnt_rdata : '0;
  assign scan_hit = scan_pend && (scan_cnt != '0) && list_room;

  // Drive RAM ports from the sequencer state
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = tidx;
    cnt_wdata = new_cnt;
    cnt_raddr = s_axis_tdata[FUNC_W +: IW];
    lst_we    = 1'b0;
    lst_waddr = distinct_count[IW-1:0];
    lst_wdata = PICK_W'(piece_type);
    lst_raddr = div_rem[IW-1:0];
    div_start = 1'b0;
    unique case (state)
      S_READ: begin
        cnt_we = add_ok || rem_ok;
        lst_we = add_ok && (cur_cnt == '0) && list_room;
      end
      S_SCAN: begin
        cnt_raddr = scan_t[IW-1:0];
        lst_we    = scan_hit;
        lst_wdata = PICK_W'(scan_idx);
      end
      S_PICK: begin
        div_start = (distinct_count != '0);
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_READ;
      S_READ: begin
        if (rem_ok && cur_cnt == COUNT_BITS'(1)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_PICK;
        end
      end
      S_SCAN: if (scan_t >= eff_types && !scan_pend) state_next = S_PICK;
      S_PICK: begin
        if (distinct_count == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:  if (div_done) state_next = S_LIST;
      S_LIST: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_types   <= ACTIVE_RESET;
      cnt_vld        <= '0;
      total_count    <= '0;
      distinct_count <= '0;
      scan_pend      <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        active_types <= cfg_wdata;
      end
      // Update the table after the count fetch
      if (state == S_READ) begin
        if (func == FN_CLR) begin
          cnt_vld        <= '0;
          total_count    <= '0;
          distinct_count <= '0;
        end
        if (add_ok) begin
          cnt_vld[tidx] <= 1'b1;
          total_count   <= total_count + TOTAL_W'(1);
          if (cur_cnt == '0 && list_room) begin
            distinct_count <= distinct_count + DW'(1);
          end
        end
        if (rem_ok) begin
          if (total_count != '0) begin
            total_count <= total_count - TOTAL_W'(1);
          end
          if (cur_cnt == COUNT_BITS'(1)) begin
            distinct_count <= '0;
          end
        end
      end
      // Rebuild the list during the scan
      if (state == S_SCAN) begin
        scan_pend <= scan_t < eff_types;
        if (scan_hit) begin
          distinct_count <= distinct_count + DW'(1);
        end
      end else begin
        scan_pend <= 1'b0;
      end
      // Hold the result until taken
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        func         <= s_axis_tdata[0 +: FUNC_W];
        piece_type   <= s_axis_tdata[FUNC_W +: TYPE_W];
        random_value <= s_axis_tdata[FUNC_W + TYPE_W +: RND_W];
        in_range     <= 32'(s_axis_tdata[FUNC_W +: TYPE_W]) < 32'(eff_types);
        scan_t       <= '0;
      end
      S_READ: begin
        status <= op_status;
        if (!in_range || func == FN_CLR) begin
          type_count <= '0;
        end else if (new_cnt_ext > CEW'(16'hFFFF)) begin
          type_count <= 16'hFFFF;
        end else begin
          type_count <= new_cnt_ext[TCNT_W-1:0];
        end
      end
      S_SCAN: begin
        if (scan_t < eff_types) begin
          scan_t   <= scan_t + DW'(1);
          scan_idx <= scan_t[IW-1:0];
        end
      end
      S_PICK: begin
        picked_type <= '0;
        pick_valid  <= 1'b0;
      end
      S_LIST: begin
        picked_type <= lst_rdata;
        pick_valid  <= 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {pick_valid, picked_type, DOUT_W'(distinct_count),
                           total_count, type_count, status};
        end
      end
      default: begin
        scan_t <= scan_t;
      end
    endcase
  end

  // Per-type counts; entries not yet written read as zero through cnt_vld
  tctrp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_TYPES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // List of present types
  tctrp_ram #(
    .WIDTH (PICK_W),
    .DEPTH (MAX_TYPES)
  ) u_lst_ram (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  // random_value mod distinct_count
  tctrp_mod #(
    .DIV_BITS (DW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (random_value),
    .divisor  (distinct_count),
    .done     (div_done),
    .rem      (div_rem)
  );

endmodule

// ----- dv/type_count_table_random_pick_top_tb.sv -----
// Self-checking testbench for the type count table with random pick.
`timescale 1ns / 1ps

module type_count_table_random_pick_top_tb;
  import tctrp_pkg::*;

  localparam int unsigned NUM_TYPES       = 16;
  localparam logic [15:0] COUNT_TOP       = 16'hFFFF;
  localparam logic [FUNC_W-1:0] FN_NOP    = 2'd3;
  localparam int SETTLE_CYCLES            = 48;
  localparam int STALL_LIMIT              = 5000;
  localparam int ITEMS_PER_PHASE          = 440;
  localparam int HOLD_OFF_CYCLES          = 300;
  localparam int DEEP_COUNT               = 60;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [TYPE_W-1:0] ptype;
    logic [RND_W-1:0]  rnd;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [TCNT_W-1:0]  tcount;
    logic [TOTAL_W-1:0] total;
    logic [DOUT_W-1:0]  distinct;
    logic [PICK_W-1:0]  picked;
    logic               pvalid;
  } result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [ACTIVE_W-1:0]  cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [1:0] func, [9:2] piece_type, [25:10] random_value, [31:26] zero
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [1:0] status, [17:2] type_count, [37:18] total_left, [42:38] distinct_left,
  // [46:43] picked_type, [47] pick_valid
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow of the count table, updated as requests are accepted
  logic [ACTIVE_W-1:0]  shadow_active;
  logic [TCNT_W-1:0]    shadow_tally [NUM_TYPES];
  logic [PICK_W-1:0]    shadow_present [NUM_TYPES];
  logic [DOUT_W-1:0]    shadow_distinct;
  logic [TOTAL_W-1:0]   shadow_total;
  result_t              table_results_due [$];

  // Stimulus-side bookkeeping
  logic [ACTIVE_W-1:0]  cur_active;
  int                   items_sent;
  int                   send_gap_pct;
  int                   recv_stall_pct;
  int                   hold_left;
  int                   mismatch_count;
  int                   idle_cycles;

  type_count_table_random_pick_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Rebuild the present list from the types below the active limit
  function automatic void rebuild_present_list(input logic [ACTIVE_W-1:0] lim);
    shadow_distinct = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (t < lim && shadow_tally[t] != '0 && shadow_distinct < NUM_TYPES) begin
        shadow_present[shadow_distinct[3:0]] = t[PICK_W-1:0];
        shadow_distinct++;
      end
    end
  endfunction

  // Apply one request to the shadow table and return the result it produces
  function automatic result_t update_count_table(input request_t r);
    result_t              res;
    logic [ACTIVE_W-1:0]  lim;
    logic                 in_range;
    logic [PICK_W-1:0]    slot;
    lim        = (shadow_active > NUM_TYPES) ? ACTIVE_W'(NUM_TYPES) : shadow_active;
    in_range   = ({1'b0, r.ptype} < {4'b0, lim});
    slot       = r.ptype[PICK_W-1:0];
    res.status = ST_OK;
    case (r.op)
      FN_ADD: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (shadow_tally[slot] == COUNT_TOP || shadow_total == TOTAL_MAX) begin
          res.status = ST_SAT;
        end else begin
          shadow_tally[slot]++;
          shadow_total++;
          if (shadow_tally[slot] == 16'd1 && shadow_distinct < NUM_TYPES) begin
            shadow_present[shadow_distinct[3:0]] = slot;
            shadow_distinct++;
          end
        end
      end
      FN_REM: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (shadow_tally[slot] == '0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_tally[slot]--;
          if (shadow_total != '0) shadow_total--;
          if (shadow_tally[slot] == '0) rebuild_present_list(lim);
        end
      end
      FN_CLR: begin
        for (int t = 0; t < NUM_TYPES; t++) shadow_tally[t] = '0;
        shadow_total    = '0;
        shadow_distinct = '0;
      end
      default: begin
      end
    endcase
    res.tcount   = in_range ? shadow_tally[slot] : '0;
    res.total    = shadow_total;
    res.distinct = shadow_distinct;
    if (shadow_distinct != '0) begin
      res.picked = shadow_present[(r.rnd % shadow_distinct) & 16'hF];
      res.pvalid = 1'b1;
    end else begin
      res.picked = '0;
      res.pvalid = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Predict on request accept, compare on result accept, track register writes
  always @(posedge clk) begin
    request_t req;
    result_t  got;
    result_t  want;
    if (rst) begin
      shadow_active   = ACTIVE_RESET;
      shadow_distinct = '0;
      shadow_total    = '0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        shadow_tally[t]   = '0;
        shadow_present[t] = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.op    = s_axis_tdata[1:0];
        req.ptype = s_axis_tdata[9:2];
        req.rnd   = s_axis_tdata[25:10];
        table_results_due.push_back(update_count_table(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status   = m_axis_tdata[1:0];
        got.tcount   = m_axis_tdata[17:2];
        got.total    = m_axis_tdata[37:18];
        got.distinct = m_axis_tdata[42:38];
        got.picked   = m_axis_tdata[46:43];
        got.pvalid   = m_axis_tdata[47];
        if (table_results_due.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          want = table_results_due.pop_front();
          check_field("status", got.status, want.status);
          check_field("type_count", got.tcount, want.tcount);
          check_field("total_left", got.total, want.total);
          check_field("distinct_left", got.distinct, want.distinct);
          check_field("picked_type", got.picked, want.picked);
          check_field("pick_valid", got.pvalid, want.pvalid);
        end
      end
      if (cfg_we) shadow_active = cfg_wdata;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("type_count_table_random_pick_top regression: fail");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [TYPE_W-1:0] ptype,
                              input logic [RND_W-1:0] rnd);
    if (send_gap_pct != 0) begin
      while ($urandom_range(99) < send_gap_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rnd, ptype, op};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (table_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_types(input logic [ACTIVE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_active = value;
  endtask

  function automatic int usable_types();
    return (cur_active > NUM_TYPES) ? NUM_TYPES : int'(cur_active);
  endfunction

  function automatic logic [RND_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return RND_W'($urandom);
  endfunction

  task automatic send_random_request;
    int                roll;
    logic [FUNC_W-1:0] op;
    logic [TYPE_W-1:0] ptype;
    roll = $urandom_range(99);
    if (roll < 45)      op = FN_ADD;
    else if (roll < 93) op = FN_REM;
    else if (roll < 96) op = FN_NOP;
    else                op = FN_CLR;
    if ($urandom_range(99) < 85 && usable_types() > 0)
      ptype = TYPE_W'($urandom_range(usable_types() - 1));
    else
      ptype = TYPE_W'($urandom_range(255));
    send_request(op, ptype, pick_value());
  endtask

  // Fill a few types, then take every piece back in shuffled order, with noise
  task automatic send_fill_drain_burst;
    logic [TYPE_W-1:0] pool [$];
    logic [TYPE_W-1:0] take_back [$];
    logic [TYPE_W-1:0] tmp;
    int                kinds;
    int                k;
    kinds = $urandom_range(4, 1);
    for (int j = 0; j < kinds; j++) pool.push_back(TYPE_W'($urandom_range(usable_types() - 1)));
    foreach (pool[j]) begin
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9) == 0) send_random_request();
        send_request(FN_ADD, pool[j], pick_value());
        take_back.push_back(pool[j]);
      end
    end
    for (int j = take_back.size() - 1; j > 0; j--) begin
      k            = $urandom_range(j);
      tmp          = take_back[j];
      take_back[j] = take_back[k];
      take_back[k] = tmp;
    end
    foreach (take_back[j]) begin
      if ($urandom_range(9) == 0) send_random_request();
      send_request(FN_REM, take_back[j], pick_value());
    end
  endtask

  // Empty table: no-op, remove from nothing, clear of nothing
  task automatic test_empty_table;
    send_request(FN_NOP, 8'd0, 16'h0000);
    send_request(FN_REM, 8'd0, 16'hFFFF);
    send_request(FN_CLR, 8'd3, 16'h1234);
    drain_results();
  endtask

  // Adds, removes, out of range types, list rebuild and clear
  task automatic test_add_remove_pick;
    send_request(FN_ADD, 8'd0, 16'h0000);
    send_request(FN_ADD, 8'd15, 16'hFFFF);
    send_request(FN_ADD, 8'd5, 16'h0001);
    send_request(FN_ADD, 8'd5, 16'h0002);
    send_request(FN_ADD, 8'd16, 16'h0003);
    send_request(FN_ADD, 8'd255, 16'hFFFF);
    send_request(FN_REM, 8'd255, 16'h0000);
    send_request(FN_REM, 8'd9, 16'h0005);
    send_request(FN_REM, 8'd5, 16'h0006);
    send_request(FN_REM, 8'd5, 16'hFFFF);
    send_request(FN_REM, 8'd0, 16'h0001);
    send_request(FN_NOP, 8'd15, 16'hFFFF);
    send_request(FN_CLR, 8'd0, 16'h0000);
    drain_results();
  endtask

  // Register extremes, and lowering the limit while counts are held
  task automatic test_active_types;
    write_active_types(5'd1);
    send_request(FN_ADD, 8'd0, 16'h0007);
    send_request(FN_ADD, 8'd1, 16'h0008);
    drain_results();
    write_active_types(5'd0);
    send_request(FN_ADD, 8'd0, 16'h0009);
    send_request(FN_REM, 8'd0, 16'h000A);
    drain_results();
    write_active_types(5'd31);
    send_request(FN_ADD, 8'd15, 16'h000B);
    send_request(FN_ADD, 8'd16, 16'h000C);
    drain_results();
    write_active_types(5'd16);
    send_request(FN_ADD, 8'd10, 16'h000D);
    send_request(FN_ADD, 8'd3, 16'h000E);
    drain_results();
    // rebuild only walks the types below four, so ten drops out of the list
    write_active_types(5'd4);
    send_request(FN_REM, 8'd3, 16'h000F);
    send_request(FN_REM, 8'd10, 16'h0010);
    send_request(FN_ADD, 8'd2, 16'hFFFF);
    drain_results();
    write_active_types(5'd17);
    send_request(FN_NOP, 8'd0, 16'h0011);
    send_request(FN_ADD, 8'd10, 16'h0012);
    send_request(FN_REM, 8'd15, 16'h0013);
    drain_results();
  endtask

  // Random traffic at one register setting, optionally with a result hold-off
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [ACTIVE_W-1:0] active, input bit squeeze);
    int first_item;
    write_active_types(active);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
    first_item     = items_sent;
    if (squeeze) begin
      hold_left = HOLD_OFF_CYCLES;
      repeat (8) send_random_request();
    end
    while (items_sent - first_item < ITEMS_PER_PHASE) begin
      if ($urandom_range(9) < 6) send_fill_drain_burst();
      else send_random_request();
    end
    drain_results();
  endtask

  // Pile many pieces on one type, then step back and clear
  task automatic test_deep_count;
    write_active_types(5'd16);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_request(FN_CLR, 8'd0, 16'h0000);
    for (int i = 0; i < DEEP_COUNT; i++) send_request(FN_ADD, 8'd7, RND_W'($urandom));
    send_request(FN_REM, 8'd7, 16'h0000);
    send_request(FN_ADD, 8'd7, 16'h0001);
    send_request(FN_ADD, 8'd2, 16'h0002);
    send_request(FN_CLR, 8'd0, 16'h0003);
    drain_results();
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    m_axis_tready  <= 1'b0;
    cur_active     = ACTIVE_RESET;
    items_sent     = 0;
    send_gap_pct   = 15;
    recv_stall_pct = 50;
    hold_left      = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_add_remove_pick();
    test_active_types();
    test_random_traffic(15, 50, 5'd16, 1'b1);
    test_random_traffic(50, 15, ACTIVE_W'($urandom_range(31, 1)), 1'b0);
    test_random_traffic(0, 0, ACTIVE_W'($urandom_range(31, 1)), 1'b0);
    test_deep_count();

    if (table_results_due.size() != 0)
      report_mismatch("results never returned", table_results_due.size(), 0);
    if (mismatch_count == 0)
      $display("type_count_table_random_pick_top regression: pass");
    else
      $display("type_count_table_random_pick_top regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/tctrp_pkg.sv
src/tctrp_ram.sv
src/tctrp_mod.sv
src/type_count_table_random_pick_top.sv
dv/type_count_table_random_pick_top_tb.sv
